### rtl/unicode_transcoder_top_defines.svh
// assertion macros for the transcoder top level
`ifndef UNICODE_TRANSCODER_TOP_DEFINES_SVH
`define UNICODE_TRANSCODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define UTC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define UTC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/utc_pkg.sv
package utc_pkg;

	// encoding codes
	localparam logic [2:0] ENC_ASCII  = 3'd0;
	localparam logic [2:0] ENC_LATIN1 = 3'd1;
	localparam logic [2:0] ENC_UTF8   = 3'd2;
	localparam logic [2:0] ENC_UTF16  = 3'd3;
	localparam logic [2:0] ENC_UTF32  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_INVALID     = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE  = 2'd2;
	localparam logic [1:0] ST_UNENCODABLE = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET = 1'd1;

	// reset values of the registers
	localparam logic [2:0] SOURCE_RESET = ENC_UTF8;
	localparam logic [2:0] TARGET_RESET = ENC_UTF32;

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last_of_run;
	} out_item_t;

	// one job: either an error report or a finished code point
	typedef struct packed {
		logic        is_err;
		logic [1:0]  status;
		logic [31:0] cp;
	} job_t;

	// queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/utc_front.sv
module utc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        source_enc,
	input  logic              clear,
	input  logic              in_valid,
	output logic              in_ready,
	input  utc_pkg::in_item_t in_data,
	input  utc_pkg::q_stat_t  q_stat,
	output logic              push,
	output utc_pkg::job_t     push_job
);

	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic [2:0]  exp_q;

	logic [23:0] pend_d;
	logic [1:0]  cnt_d;
	logic [2:0]  exp_d;

	logic [7:0]  b;
	logic        last;
	logic [2:0]  total;
	logic [15:0] w0_first;
	logic [15:0] w1_last;
	logic        hi_sur;
	logic [7:0]  seq1;
	logic [7:0]  seq2;
	logic        cont_ok;
	logic [31:0] utf8_cp;

	logic        do_err;
	logic [1:0]  err_code;
	logic        do_cp;
	logic [31:0] cp_val;
	logic        do_start;
	logic [2:0]  start_len;

	logic        accept;

	assign b        = in_data.in_byte;
	assign last     = in_data.end_of_buffer;
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// fields of a sequence that may complete with this byte
	assign total    = {1'b0, cnt_q} + 3'd1;
	assign w0_first = {b, pend_q[7:0]};
	assign w1_last  = {b, pend_q[23:16]};
	assign hi_sur   = (w0_first >= 16'hd800) && (w0_first <= 16'hdbff);
	assign seq1     = (cnt_q > 2'd1) ? pend_q[15:8] : b;
	assign seq2     = (cnt_q > 2'd2) ? pend_q[23:16] : b;

	// utf-8 continuation check and assembly of the code point
	always_comb begin
		cont_ok = 1'b1;
		utf8_cp = '0;
		case (total)
			3'd2: begin
				cont_ok = (seq1[7:6] == 2'b10);
				utf8_cp = {21'd0, pend_q[4:0], seq1[5:0]};
			end
			3'd3: begin
				cont_ok = (seq1[7:6] == 2'b10) && (seq2[7:6] == 2'b10);
				utf8_cp = {16'd0, pend_q[3:0], seq1[5:0], seq2[5:0]};
			end
			default: begin
				cont_ok = (seq1[7:6] == 2'b10) && (seq2[7:6] == 2'b10) && (b[7:6] == 2'b10);
				utf8_cp = {11'd0, pend_q[2:0], seq1[5:0], seq2[5:0], b[5:0]};
			end
		endcase
	end

	// classify the byte and work out the next partial state
	always_comb begin
		do_err    = 1'b0;
		err_code  = utc_pkg::ST_OK;
		do_cp     = 1'b0;
		cp_val    = '0;
		do_start  = 1'b0;
		start_len = 3'd0;
		pend_d    = pend_q;
		cnt_d     = cnt_q;
		exp_d     = exp_q;

		if (source_enc > utc_pkg::ENC_UTF32) begin
			do_err   = 1'b1;
			err_code = utc_pkg::ST_INVALID;
		end else if (cnt_q == 2'd0) begin
			// lead byte
			case (source_enc)
				utc_pkg::ENC_ASCII: begin
					if (b[7]) begin
						do_err   = 1'b1;
						err_code = utc_pkg::ST_INVALID;
					end else begin
						do_cp  = 1'b1;
						cp_val = {24'd0, b};
					end
				end
				utc_pkg::ENC_LATIN1: begin
					do_cp  = 1'b1;
					cp_val = {24'd0, b};
				end
				utc_pkg::ENC_UTF8: begin
					if (!b[7]) begin
						do_cp  = 1'b1;
						cp_val = {24'd0, b};
					end else if (b[7:5] == 3'b110) begin
						do_start  = 1'b1;
						start_len = 3'd2;
					end else if (b[7:4] == 4'b1110) begin
						do_start  = 1'b1;
						start_len = 3'd3;
					end else if (b[7:3] == 5'b11110) begin
						do_start  = 1'b1;
						start_len = 3'd4;
					end else begin
						do_err   = 1'b1;
						err_code = utc_pkg::ST_INVALID;
					end
				end
				utc_pkg::ENC_UTF16: begin
					do_start  = 1'b1;
					start_len = 3'd2;
				end
				default: begin
					do_start  = 1'b1;
					start_len = 3'd4;
				end
			endcase
			if (do_start) begin
				pend_d = {16'd0, b};
				cnt_d  = 2'd1;
				exp_d  = start_len;
				if (last) begin
					do_err   = 1'b1;
					err_code = utc_pkg::ST_INCOMPLETE;
				end
			end
		end else if (exp_q < 3'd2 || exp_q > 3'd4 || total > exp_q) begin
			do_err   = 1'b1;
			err_code = utc_pkg::ST_INVALID;
		end else if (total < exp_q) begin
			// sequence still open
			if (source_enc == utc_pkg::ENC_UTF16 && total == 3'd2 && hi_sur) begin
				exp_d = 3'd4;
			end
			case (cnt_q)
				2'd1:    pend_d[15:8]  = b;
				2'd2:    pend_d[23:16] = b;
				default: pend_d        = pend_q;
			endcase
			cnt_d = total[1:0];
			if (last) begin
				do_err   = 1'b1;
				err_code = utc_pkg::ST_INCOMPLETE;
			end
		end else begin
			// sequence complete
			if (source_enc == utc_pkg::ENC_UTF8) begin
				if (!cont_ok) begin
					do_err   = 1'b1;
					err_code = utc_pkg::ST_INVALID;
				end else begin
					do_cp  = 1'b1;
					cp_val = utf8_cp;
				end
			end else if (source_enc == utc_pkg::ENC_UTF16) begin
				if (total == 3'd2) begin
					if (hi_sur) begin
						// high surrogate: wait for the low half
						exp_d        = 3'd4;
						pend_d[15:8] = b;
						cnt_d        = 2'd2;
						if (last) begin
							do_err   = 1'b1;
							err_code = utc_pkg::ST_INCOMPLETE;
						end
					end else begin
						do_cp  = 1'b1;
						cp_val = {16'd0, w0_first};
					end
				end else if (w1_last < 16'hdc00 || w1_last > 16'hdfff) begin
					do_err   = 1'b1;
					err_code = utc_pkg::ST_INVALID;
				end else begin
					do_cp  = 1'b1;
					cp_val = 32'h0001_0000 + {12'd0, pend_q[9:0], w1_last[9:0]};
				end
			end else begin
				do_cp  = 1'b1;
				cp_val = {b, pend_q};
			end
		end

		// errors and finished code points drop the partial state
		if (do_err || do_cp) begin
			pend_d = '0;
			cnt_d  = 2'd0;
			exp_d  = 3'd0;
		end
	end

	assign push            = accept && (do_err || do_cp);
	assign push_job.is_err = do_err;
	assign push_job.status = do_err ? err_code : utc_pkg::ST_OK;
	assign push_job.cp     = do_err ? 32'd0 : cp_val;

	// partial sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= 2'd0;
			exp_q  <= 3'd0;
		end else if (clear) begin
			pend_q <= '0;
			cnt_q  <= 2'd0;
			exp_q  <= 3'd0;
		end else if (accept) begin
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
			exp_q  <= exp_d;
		end
	end

endmodule

### rtl/utc_queue.sv
module utc_queue #(
	parameter int DEPTH = utc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  utc_pkg::job_t    push_job,
	input  logic             pop,
	output utc_pkg::job_t    head,
	output utc_pkg::q_stat_t stat
);

	// depth of two or more
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	utc_pkg::job_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/utc_back.sv
module utc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         target_enc,
	input  utc_pkg::q_stat_t   q_stat,
	input  utc_pkg::job_t      head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output utc_pkg::out_item_t out_data
);

	logic [3:0][7:0] enc_bytes;
	logic [1:0]      enc_last;
	logic [1:0]      enc_status;
	logic [31:0]     cp;
	logic [31:0]     sur_v;
	logic [15:0]     sur_w0;
	logic [15:0]     sur_w1;

	logic            cur_valid_q;
	logic [3:0][7:0] cur_bytes_q;
	logic [1:0]      cur_last_q;
	logic [1:0]      cur_idx_q;
	logic [1:0]      cur_status_q;

	logic               out_valid_q;
	utc_pkg::out_item_t out_q;

	logic out_free;
	logic emit;
	logic cur_done;

	assign cp     = head.cp;
	assign sur_v  = cp - 32'h0001_0000;
	assign sur_w0 = 16'hd800 + sur_v[25:10];
	assign sur_w1 = {6'b110111, sur_v[9:0]};

	// encode the head job into one to four bytes
	always_comb begin
		enc_bytes  = '0;
		enc_last   = 2'd0;
		enc_status = utc_pkg::ST_OK;
		if (head.is_err) begin
			enc_status = head.status;
		end else begin
			case (target_enc)
				utc_pkg::ENC_ASCII: begin
					if (cp > 32'h7f) begin
						enc_status = utc_pkg::ST_UNENCODABLE;
					end else begin
						enc_bytes[0] = cp[7:0];
					end
				end
				utc_pkg::ENC_LATIN1: begin
					if (cp > 32'hff) begin
						enc_status = utc_pkg::ST_UNENCODABLE;
					end else begin
						enc_bytes[0] = cp[7:0];
					end
				end
				utc_pkg::ENC_UTF8: begin
					if (cp < 32'h80) begin
						enc_bytes[0] = cp[7:0];
					end else if (cp < 32'h800) begin
						enc_bytes[0] = {3'b110, cp[10:6]};
						enc_bytes[1] = {2'b10, cp[5:0]};
						enc_last     = 2'd1;
					end else if (cp < 32'h1_0000) begin
						enc_bytes[0] = {4'b1110, cp[15:12]};
						enc_bytes[1] = {2'b10, cp[11:6]};
						enc_bytes[2] = {2'b10, cp[5:0]};
						enc_last     = 2'd2;
					end else begin
						enc_bytes[0] = 8'hf0 | cp[25:18];
						enc_bytes[1] = {2'b10, cp[17:12]};
						enc_bytes[2] = {2'b10, cp[11:6]};
						enc_bytes[3] = {2'b10, cp[5:0]};
						enc_last     = 2'd3;
					end
				end
				utc_pkg::ENC_UTF16: begin
					if (cp < 32'h1_0000) begin
						enc_bytes[0] = cp[7:0];
						enc_bytes[1] = cp[15:8];
						enc_last     = 2'd1;
					end else begin
						enc_bytes[0] = sur_w0[7:0];
						enc_bytes[1] = sur_w0[15:8];
						enc_bytes[2] = sur_w1[7:0];
						enc_bytes[3] = sur_w1[15:8];
						enc_last     = 2'd3;
					end
				end
				utc_pkg::ENC_UTF32: begin
					enc_bytes = cp;
					enc_last  = 2'd3;
				end
				default: begin
					enc_status = utc_pkg::ST_UNENCODABLE;
				end
			endcase
		end
	end

	// byte emitter handshake
	assign out_free = !out_valid_q || out_ready;
	assign emit     = cur_valid_q && out_free;
	assign cur_done = emit && (cur_idx_q == cur_last_q);
	assign pop      = !q_stat.empty && (!cur_valid_q || cur_done);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// control of the emitter and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_idx_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				cur_idx_q   <= 2'd0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				cur_idx_q <= cur_idx_q + 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the emitter and the output register
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bytes_q  <= enc_bytes;
			cur_last_q   <= enc_last;
			cur_status_q <= enc_status;
		end
		if (emit) begin
			out_q.out_byte    <= cur_bytes_q[cur_idx_q];
			out_q.status      <= cur_status_q;
			out_q.last_of_run <= (cur_idx_q == cur_last_q);
		end
	end

endmodule

### rtl/unicode_transcoder_top.sv
// Byte-serial text transcoder between ASCII, Latin-1, UTF-8, UTF-16LE and UTF-32LE.
// The front end takes one source byte per cycle whenever its job queue has room,
// gathers multi-byte sequences and hands each finished code point or error to the
// queue; the back end re-encodes it and puts out one result byte per cycle while it holds
// a job and out_ready is high. A byte that completes a code point yields one to four
// output bytes: one for ASCII and Latin-1 targets and every error, up to four for UTF-8
// and UTF-16, always four for UTF-32, so the sustained rate is set by the back end's byte
// emitter. Each result passes through the queue, emitter and output registers in turn.
// Configuration writes clear any partial sequence and must be made with the block idle.
`include "unicode_transcoder_top_defines.svh"

module unicode_transcoder_top #(
	parameter int QUEUE_DEPTH = utc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  utc_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output utc_pkg::out_item_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [utc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [utc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [2:0]       source_q;
	logic [2:0]       target_q;
	logic             cfg_wr;
	logic             push;
	logic             pop;
	utc_pkg::job_t    push_job;
	utc_pkg::job_t    head;
	utc_pkg::q_stat_t q_stat;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= utc_pkg::SOURCE_RESET;
			target_q <= utc_pkg::TARGET_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				utc_pkg::CFG_SOURCE: source_q <= cfg_data;
				utc_pkg::CFG_TARGET: target_q <= cfg_data;
				default:             source_q <= source_q;
			endcase
		end
	end

	utc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.source_enc (source_q),
		.clear      (cfg_wr),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_job   (push_job)
	);

	utc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	utc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.target_enc (target_q),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	// checks
	`UTC_ASSERT_NOW(a_push_room, push, !q_stat.full, "job pushed into a full queue")
	`UTC_ASSERT_NOW(a_pop_data, pop, !q_stat.empty, "job popped from an empty queue")
	`UTC_ASSERT_NOW(a_err_shape, out_valid && out_data.status != utc_pkg::ST_OK,
		out_data.out_byte == 8'd0 && out_data.last_of_run, "error result not a lone zero byte")
	`UTC_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !out_data.last_of_run,
		out_valid, "gap inside a multi-byte run")

endmodule
